// File: hw/rtl/pws_pkg.sv
// Package for the smoothed-term PID controller: widths, fixed-point constants,
// register indexes, the micro-instruction format and the microcode ROM.
// Depends on nothing; every other file of the block imports it.
package pws_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int GAIN_W     = 32;
	localparam int WGT_W      = 17;
	localparam int TOL_W      = 31;
	localparam int W_FRAC     = 16;
	localparam int ADDR_W     = 5;
	localparam int APB_W      = 32;

	localparam int EXT_W  = DATA_WIDTH + 1;
	localparam int MULA_W = GAIN_W + 1;
	localparam int PROD_W = MULA_W + DATA_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam int INT_W  = (DATA_WIDTH + 1 > TOL_W + 1) ? DATA_WIDTH + 1 : TOL_W + 1;
	localparam int CMP_W  = (DATA_WIDTH > TOL_W) ? DATA_WIDTH : TOL_W;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic        [WGT_W-1:0]      wgt_t;

	localparam wgt_t W_ONE   = 17'd65536;
	localparam wgt_t MIX_RAW = 17'd13107;
	localparam wgt_t MIX_AVG = 17'd52429;

	localparam data_t DMAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DMIN     = ~DMAX;
	localparam acc_t  ACC_DMAX = ACC_W'(DMAX);
	localparam acc_t  ACC_DMIN = ACC_W'(DMIN);
	localparam acc_t  HALF_W   = {{(ACC_W-W_FRAC){1'b0}}, 1'b1, {(W_FRAC-1){1'b0}}};
	localparam acc_t  HALF_F   = {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_SMOOTH_P,
		REG_SMOOTH_D, REG_INT_LIMIT, REG_ERR_TOL, REG_SLOPE_TOL
	} reg_idx_t;

	typedef enum logic [3:0] {
		MA_NONE, MA_WP_OLD, MA_WP_NEW, MA_WD_OLD, MA_WD_NEW,
		MA_RAW, MA_AVG, MA_GP, MA_GI, MA_GD
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_NONE, MB_AVG_E, MB_ERR, MB_AVG_D, MB_SLOPE, MB_PMIX, MB_INTEG, MB_DMIX
	} mul_b_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

	typedef enum logic [2:0] {WB_NONE, WB_AVG_E, WB_AVG_D, WB_PMIX, WB_DMIX, WB_DRIVE} wb_t;

	typedef enum logic [1:0] {ALU_NONE, ALU_ERR, ALU_SLOPE_INT} alu_t;

	typedef enum logic [1:0] {J_NEXT, J_WAIT_IN, J_FINISH} jmp_t;

	typedef struct packed {
		mul_a_t  ma;
		mul_b_t  mb;
		acc_op_t acc;
		wb_t     wb;
		alu_t    alu;
		jmp_t    jmp;
	} ctrl_t;

	localparam int N_STEPS = 14;
	localparam int STEP_W  = $clog2(N_STEPS);

	// The program: one multiply issued per step, its product accumulated in
	// the following step, and each result rounded and written back once summed.
	localparam ctrl_t UCODE [N_STEPS] = '{
		'{ma: MA_NONE,   mb: MB_NONE,  acc: ACC_HOLD, wb: WB_NONE,  alu: ALU_ERR,       jmp: J_WAIT_IN},
		'{ma: MA_WP_OLD, mb: MB_AVG_E, acc: ACC_HOLD, wb: WB_NONE,  alu: ALU_SLOPE_INT, jmp: J_NEXT},
		'{ma: MA_WP_NEW, mb: MB_ERR,   acc: ACC_LOAD, wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_WD_OLD, mb: MB_AVG_D, acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_WD_NEW, mb: MB_SLOPE, acc: ACC_LOAD, wb: WB_AVG_E, alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_RAW,    mb: MB_ERR,   acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_AVG,    mb: MB_AVG_E, acc: ACC_LOAD, wb: WB_AVG_D, alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_RAW,    mb: MB_SLOPE, acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_AVG,    mb: MB_AVG_D, acc: ACC_LOAD, wb: WB_PMIX,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_GP,     mb: MB_PMIX,  acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_GI,     mb: MB_INTEG, acc: ACC_LOAD, wb: WB_DMIX,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_GD,     mb: MB_DMIX,  acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_NONE,   mb: MB_NONE,  acc: ACC_ADD,  wb: WB_NONE,  alu: ALU_NONE,      jmp: J_NEXT},
		'{ma: MA_NONE,   mb: MB_NONE,  acc: ACC_HOLD, wb: WB_DRIVE, alu: ALU_NONE,      jmp: J_FINISH}
	};

	// Saturate a value one bit wider than the data path.
	function automatic data_t sat_ext(input logic signed [EXT_W-1:0] v);
		if (v[EXT_W-1] != v[EXT_W-2]) begin
			return v[EXT_W-1] ? DMIN : DMAX;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	// Round half up by the weight fraction or by the data fraction, then saturate.
	function automatic data_t round_sat(input acc_t a, input logic by_frac);
		acc_t s_w;
		acc_t s_f;
		acc_t s;
		s_w = (a + HALF_W) >>> W_FRAC;
		s_f = (a + HALF_F) >>> FRAC_BITS;
		s   = by_frac ? s_f : s_w;
		if (s > ACC_DMAX) begin
			return DMAX;
		end else if (s < ACC_DMIN) begin
			return DMIN;
		end
		return s[DATA_WIDTH-1:0];
	endfunction

endpackage

// File: hw/rtl/pws_if.sv
// Valid/ready channel interfaces for the sample and result beats of the
// smoothed-term PID controller. Depends on pws_pkg for the data type.
interface pws_in_if import pws_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t measured;
	data_t target;
	logic  clear_integral;

	modport source (output valid, measured, target, clear_integral, input ready);
	modport sink   (input valid, measured, target, clear_integral, output ready);
endinterface

interface pws_out_if import pws_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t drive;
	logic  settled;

	modport source (output valid, drive, settled, input ready);
	modport sink   (input valid, drive, settled, output ready);
endinterface

// File: hw/rtl/pid_with_smoothed_terms.sv
// PID controller with averaged proportional and derivative terms, top level.
// Depends on pws_pkg and on the channel interfaces in pws_if.sv.
//
// Use: a sample beat on the sample channel carries a measured value, a target
// (both signed Q16.16) and a flag that clears the integral before the update.
// Each sample yields exactly one result beat on the result channel: the
// saturated drive value and a settled flag. Gains, averaging weights, the
// integral clamp and the settling tolerances are written over the APB port,
// one register per 32-bit word, and are to be written only while the block is
// idle; the block itself does not enforce this. pready is tied high and reads
// return the stored register. A sample is accepted in step 0 of a 14-step
// microprogram; one shared 33 x 32 bit multiplier does the eleven products of
// each update, one per step, and the final step loads the result into the
// output register before the program returns to step 0 for the next sample.
// The output register holds the result while the receiver stalls; the next
// sample is accepted and worked on meanwhile, and only the final step waits
// for the output register to free up. A sample is never dropped.
// Reset (arst_n low, asynchronous) clears the controller state, restores the
// register defaults (integral clamp at its maximum, all others zero) and
// empties the output register.
module pid_with_smoothed_terms import pws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pws_in_if.sink            sample,
	pws_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready
);

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	wgt_t                     smooth_p_q, smooth_d_q;
	logic [TOL_W-1:0]         int_limit_q, err_tol_q, slope_tol_q;

	// Sequencer and controller state.
	logic [STEP_W-1:0] step_q;
	ctrl_t             ctrl;
	data_t             err_q, slope_q, last_q, avg_e_q, avg_d_q, integ_q;
	data_t             pmix_q, dmix_q;
	logic              clear_q, settled_q;
	logic signed [PROD_W-1:0] prod_s1;
	acc_t              acc_q;
	logic              res_valid_q;
	data_t             res_drive_q;
	logic              res_settled_q;

	logic              cfg_wr;
	logic              accept;
	logic              slot_free;
	logic              drive_load;
	wgt_t              mp, md;
	logic signed [MULA_W-1:0] mul_a;
	data_t             mul_b;
	logic signed [PROD_W-1:0] prod;
	data_t             wb_val;
	data_t             err_new, slope_new, integ_new;
	logic signed [INT_W-1:0] int_sum, int_lim, int_clamped;
	logic [DATA_WIDTH-1:0] mag_err, mag_slope;
	logic              settled_new;

	// APB register file.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			smooth_p_q  <= '0;
			smooth_d_q  <= '0;
			int_limit_q <= '1;
			err_tol_q   <= '0;
			slope_tol_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_GAIN_P:    gain_p_q    <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:    gain_i_q    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:    gain_d_q    <= pwdata[GAIN_W-1:0];
				REG_SMOOTH_P:  smooth_p_q  <= pwdata[WGT_W-1:0];
				REG_SMOOTH_D:  smooth_d_q  <= pwdata[WGT_W-1:0];
				REG_INT_LIMIT: int_limit_q <= pwdata[TOL_W-1:0];
				REG_ERR_TOL:   err_tol_q   <= pwdata[TOL_W-1:0];
				REG_SLOPE_TOL: slope_tol_q <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_GAIN_P:    prdata = APB_W'(gain_p_q);
			REG_GAIN_I:    prdata = APB_W'(gain_i_q);
			REG_GAIN_D:    prdata = APB_W'(gain_d_q);
			REG_SMOOTH_P:  prdata = APB_W'(smooth_p_q);
			REG_SMOOTH_D:  prdata = APB_W'(smooth_d_q);
			REG_INT_LIMIT: prdata = APB_W'(int_limit_q);
			REG_ERR_TOL:   prdata = APB_W'(err_tol_q);
			REG_SLOPE_TOL: prdata = APB_W'(slope_tol_q);
			default:       prdata = '0;
		endcase
	end

	// The control word of the current step comes straight from the ROM.
	assign ctrl = UCODE[step_q];

	// A sample is taken only in the step that waits for one.
	assign sample.ready = (ctrl.jmp == J_WAIT_IN);
	assign accept       = sample.valid && sample.ready;

	// The output register is free when empty or being emptied this cycle.
	assign slot_free  = !res_valid_q || result.ready;
	assign drive_load = (ctrl.wb == WB_DRIVE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (ctrl.jmp)
				J_NEXT:    step_q <= step_q + STEP_W'(1);
				J_WAIT_IN: if (accept) begin
					step_q <= step_q + STEP_W'(1);
				end
				J_FINISH:  if (slot_free) begin
					step_q <= '0;
				end
				default:   step_q <= '0;
			endcase
		end
	end

	// Scalar arithmetic: the error at acceptance, then slope, integral and
	// the settled test in the step after.
	assign err_new   = sat_ext(EXT_W'(sample.target) - EXT_W'(sample.measured));
	assign slope_new = sat_ext(EXT_W'(err_q) - EXT_W'(last_q));

	always_comb begin
		int_sum = INT_W'(err_q) + (clear_q ? '0 : INT_W'(integ_q));
		int_lim = INT_W'(int_limit_q);
		if (int_sum > int_lim) begin
			int_clamped = int_lim;
		end else if (int_sum < -int_lim) begin
			int_clamped = -int_lim;
		end else begin
			int_clamped = int_sum;
		end
		if (int_clamped > INT_W'(DMAX)) begin
			integ_new = DMAX;
		end else if (int_clamped < INT_W'(DMIN)) begin
			integ_new = DMIN;
		end else begin
			integ_new = int_clamped[DATA_WIDTH-1:0];
		end
	end

	// Magnitudes as unsigned values; the most negative value maps to its true size.
	assign mag_err   = err_q[DATA_WIDTH-1] ? ~err_q + 1'b1 : err_q;
	assign mag_slope = slope_new[DATA_WIDTH-1] ? ~slope_new + 1'b1 : slope_new;
	assign settled_new = (CMP_W'(mag_err) <= CMP_W'(err_tol_q)) &&
		(CMP_W'(mag_slope) <= CMP_W'(slope_tol_q));

	always_ff @(posedge clk) begin
		if (accept && ctrl.alu == ALU_ERR) begin
			err_q   <= err_new;
			clear_q <= sample.clear_integral;
		end
		if (ctrl.alu == ALU_SLOPE_INT) begin
			slope_q   <= slope_new;
			settled_q <= settled_new;
		end
	end

	// A weight above one acts as one.
	assign mp = (smooth_p_q > W_ONE) ? W_ONE : smooth_p_q;
	assign md = (smooth_d_q > W_ONE) ? W_ONE : smooth_d_q;

	// Shared multiplier operand selection.
	always_comb begin
		case (ctrl.ma)
			MA_WP_OLD: mul_a = MULA_W'(mp);
			MA_WP_NEW: mul_a = MULA_W'(W_ONE - mp);
			MA_WD_OLD: mul_a = MULA_W'(md);
			MA_WD_NEW: mul_a = MULA_W'(W_ONE - md);
			MA_RAW:    mul_a = MULA_W'(MIX_RAW);
			MA_AVG:    mul_a = MULA_W'(MIX_AVG);
			MA_GP:     mul_a = MULA_W'(gain_p_q);
			MA_GI:     mul_a = MULA_W'(gain_i_q);
			MA_GD:     mul_a = MULA_W'(gain_d_q);
			default:   mul_a = '0;
		endcase
		case (ctrl.mb)
			MB_AVG_E: mul_b = avg_e_q;
			MB_ERR:   mul_b = err_q;
			MB_AVG_D: mul_b = avg_d_q;
			MB_SLOPE: mul_b = slope_q;
			MB_PMIX:  mul_b = pmix_q;
			MB_INTEG: mul_b = integ_q;
			MB_DMIX:  mul_b = dmix_q;
			default:  mul_b = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Product register, then the accumulator, which takes it in the following step.
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		case (ctrl.acc)
			ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default:  ;
		endcase
	end

	// Averages and mixes round by the weight fraction; the drive by the data fraction.
	assign wb_val = round_sat(acc_q, ctrl.wb == WB_DRIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			avg_e_q <= '0;
			avg_d_q <= '0;
			integ_q <= '0;
		end else begin
			if (ctrl.alu == ALU_SLOPE_INT) begin
				last_q  <= err_q;
				integ_q <= integ_new;
			end
			if (ctrl.wb == WB_AVG_E) begin
				avg_e_q <= wb_val;
			end
			if (ctrl.wb == WB_AVG_D) begin
				avg_d_q <= wb_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wb == WB_PMIX) begin
			pmix_q <= wb_val;
		end
		if (ctrl.wb == WB_DMIX) begin
			dmix_q <= wb_val;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drive_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drive_load) begin
			res_drive_q   <= wb_val;
			res_settled_q <= settled_q;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.drive   = res_drive_q;
	assign result.settled = res_settled_q;

	// The step counter never runs past the end of the program.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(N_STEPS))
		else $error("step counter outside the microprogram");

	// An accepted sample always starts the program proper in the next cycle.
	a_accept_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (step_q == STEP_W'(1)))
		else $error("sequencer did not advance after a sample beat");

	// A waiting result is never overwritten before the receiver takes it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_drive_q)))
		else $error("pending result beat lost or changed");

endmodule
